// ===== rtl/core/poi_pkg.sv =====
// shared types and constants for the polygon outline inset block
package poi_pkg;

   localparam int MaxVerticesDefault = 64;
   localparam int CoordWidth = 24;
   localparam int AreaWidth = 56;

   typedef struct packed {
      logic signed [CoordWidth-1:0] vertex_x;
      logic signed [CoordWidth-1:0] vertex_y;
      logic                         last_vertex;
   } req_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] inset_x;
      logic signed [CoordWidth-1:0] inset_y;
      logic                         overflow;
      logic                         last_result;
   } rsp_type;

endpackage

// ===== rtl/core/poi_ram.sv =====
// generic simple dual-port ram (separate write and read addresses) with registered read
module poi_ram #(
   parameter int Width = 48,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/poi_datapath.sv =====
// datapath: vertex store, area sum, shared sqrt and divide units, offset math
module poi_datapath #(
   parameter int MaxVertices = poi_pkg::MaxVerticesDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load_en,
   input  poi_pkg::req_type         req_data,
   input  logic                     close_en,
   input  logic                     emit_start,
   input  logic                     emit_take,
   input  logic signed [15:0]       distance,
   output logic                     emit_busy,
   output logic                     emit_valid,
   output poi_pkg::rsp_type         emit_data
);
   localparam int AddrWidth = $clog2(MaxVertices);
   localparam int CountWidth = $clog2(MaxVertices + 1);

   // phase codes of the per-vertex sequencer
   localparam logic [3:0] PhIdle  = 4'd0;
   localparam logic [3:0] PhRdA   = 4'd1;
   localparam logic [3:0] PhRdB   = 4'd2;
   localparam logic [3:0] PhRdC   = 4'd3;
   localparam logic [3:0] PhWait  = 4'd4;
   localparam logic [3:0] PhEdge  = 4'd5;
   localparam logic [3:0] PhNrm   = 4'd6;
   localparam logic [3:0] PhSqrt  = 4'd7;
   localparam logic [3:0] PhDiv   = 4'd8;
   localparam logic [3:0] PhBis   = 4'd9;
   localparam logic [3:0] PhOut   = 4'd10;
   localparam logic [3:0] PhHold  = 4'd11;
   localparam logic [3:0] PhAreaA = 4'd12;
   localparam logic [3:0] PhAreaB = 4'd13;
   localparam logic [3:0] PhMul   = 4'd14;

   logic [CountWidth-1:0] count_ff, count_in, n_ff, n_in;
   logic signed [poi_pkg::AreaWidth-1:0] area_ff, area_in;
   logic ovf_ff, ovf_in, povf_ff, povf_in;
   logic signed [23:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [23:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic inward_neg_ff, inward_neg_in;

   logic [3:0] ph_ff, ph_in;
   logic [CountWidth-1:0] idx_ff, idx_in;
   logic [1:0] rcnt_ff, rcnt_in;
   logic signed [23:0] v_x_ff [3];
   logic signed [23:0] v_y_ff [3];
   logic signed [23:0] v_x_in [3];
   logic signed [23:0] v_y_in [3];

   // normalize/sqrt/divide working registers
   logic [1:0] stage_ff, stage_in;  // 0 prev edge,1 next edge,2 bisector
   logic signed [27:0] a_ff, a_in, b_ff, b_in;
   logic [5:0] it_ff, it_in;
   logic [47:0] rem_ff, rem_in;
   logic [24:0] root_ff, root_in;
   logic [49:0] s_ff, s_in;
   logic [1:0] dsel_ff, dsel_in;
   logic [47:0] dnum_ff, dnum_in;
   logic [31:0] dq_ff, dq_in;
   logic [25:0] drem_ff, drem_in;
   logic dneg_ff, dneg_in;
   logic signed [17:0] pnx_ff, pnx_in, pny_ff, pny_in, qnx_ff, qnx_in, qny_ff, qny_in;
   logic signed [31:0] offx_ff, offx_in, offy_ff, offy_in;
   logic mcalc_ff, mcalc_in;
   logic [47:0] mul_ff, mul_in;
   poi_pkg::rsp_type out_ff, out_in;
   logic out_valid_ff, out_valid_in;

   logic [AddrWidth-1:0] rd_addr;
   logic [47:0] rd_data;
   logic wr_en;

   poi_ram #(.Width(48), .Depth(MaxVertices)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AddrWidth-1:0]),
      .wr_data ({req_data.vertex_x, req_data.vertex_y}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign wr_en = load_en && (count_ff < CountWidth'(MaxVertices));

   function automatic logic [CountWidth-1:0] wrap_idx(input logic [CountWidth:0] v,
                                                      input logic [CountWidth-1:0] n);
      logic [CountWidth:0] r;
      r = v;
      if (r >= {1'b0, n}) r = r - {1'b0, n};
      return r[CountWidth-1:0];
   endfunction

   function automatic logic [27:0] mag28(input logic signed [27:0] v);
      return v[27] ? 28'(-v) : 28'(v);
   endfunction

   logic [CountWidth:0] rd_idx_ext;
   logic [CountWidth-1:0] rd_idx;
   always_comb begin
      unique case (rcnt_ff)
         2'd0: rd_idx_ext = {1'b0, idx_ff} + {1'b0, n_ff} - (CountWidth+1)'(1);
         2'd1: rd_idx_ext = {1'b0, idx_ff};
         default: rd_idx_ext = {1'b0, idx_ff} + (CountWidth+1)'(1);
      endcase
   end
   assign rd_idx = wrap_idx(rd_idx_ext, n_ff);
   assign rd_addr = rd_idx[AddrWidth-1:0];

   logic signed [48:0] prod_a, prod_b;
   logic [27:0] ma, mb;
   logic signed [17:0] bx_s, by_s;
   logic signed [24:0] sumx, sumy;

   always_comb begin
      count_in = count_ff; n_in = n_ff; area_in = area_ff; ovf_in = ovf_ff;
      povf_in = povf_ff; prev_x_in = prev_x_ff; prev_y_in = prev_y_ff;
      first_x_in = first_x_ff; first_y_in = first_y_ff; inward_neg_in = inward_neg_ff;
      ph_in = ph_ff; idx_in = idx_ff; rcnt_in = rcnt_ff;
      v_x_in = v_x_ff; v_y_in = v_y_ff;
      stage_in = stage_ff; a_in = a_ff; b_in = b_ff; it_in = it_ff;
      rem_in = rem_ff; root_in = root_ff; s_in = s_ff; dsel_in = dsel_ff;
      dnum_in = dnum_ff; dq_in = dq_ff; drem_in = drem_ff; dneg_in = dneg_ff;
      pnx_in = pnx_ff; pny_in = pny_ff; qnx_in = qnx_ff; qny_in = qny_ff;
      offx_in = offx_ff; offy_in = offy_ff; mcalc_in = mcalc_ff;
      mul_in = mul_ff; out_in = out_ff; out_valid_in = out_valid_ff;
      prod_a = '0; prod_b = '0; ma = mag28(a_ff); mb = mag28(b_ff);
      bx_s = '0; by_s = '0; sumx = '0; sumy = '0;

      if (emit_take) out_valid_in = 1'b0;

      // loading: one shoelace term per stored request after the first
      if (load_en) begin
         if (count_ff < CountWidth'(MaxVertices)) begin
            if (count_ff == '0) begin
               first_x_in = req_data.vertex_x; first_y_in = req_data.vertex_y;
            end else begin
               prod_a = prev_x_ff * req_data.vertex_y;
               prod_b = req_data.vertex_x * prev_y_ff;
               area_in = area_ff + poi_pkg::AreaWidth'(prod_a) - poi_pkg::AreaWidth'(prod_b);
            end
            prev_x_in = req_data.vertex_x; prev_y_in = req_data.vertex_y;
            count_in = count_ff + CountWidth'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (close_en) begin
         prod_a = prev_x_ff * first_y_ff;
         prod_b = first_x_ff * prev_y_ff;
         inward_neg_in = !((area_ff + poi_pkg::AreaWidth'(prod_a)
                            - poi_pkg::AreaWidth'(prod_b)) > 0);
         n_in = count_ff; povf_in = ovf_ff;
         count_in = '0; area_in = '0; ovf_in = 1'b0;
      end

      unique case (ph_ff)
         PhIdle: begin
            if (emit_start) begin
               idx_in = '0; rcnt_in = 2'd0; ph_in = PhRdA;
            end
         end
         PhRdA, PhRdB, PhRdC: begin
            // read address presented this cycle; data arrives next cycle
            if (ph_ff != PhRdA) begin
               v_x_in[rcnt_ff - 2'd1] = rd_data[47:24];
               v_y_in[rcnt_ff - 2'd1] = rd_data[23:0];
            end
            rcnt_in = rcnt_ff + 2'd1;
            ph_in = (ph_ff == PhRdA) ? PhRdB : (ph_ff == PhRdB) ? PhRdC : PhWait;
         end
         PhWait: begin
            v_x_in[2] = rd_data[47:24]; v_y_in[2] = rd_data[23:0];
            rcnt_in = 2'd0;
            if (n_ff < CountWidth'(3)) begin
               offx_in = '0; offy_in = '0; ph_in = PhOut;
            end else begin
               stage_in = 2'd0; ph_in = PhEdge;
            end
         end
         PhEdge: begin
            if (stage_ff == 2'd0) begin
               a_in = 28'(v_x_ff[1]) - 28'(v_x_ff[0]);
               b_in = 28'(v_y_ff[1]) - 28'(v_y_ff[0]);
            end else begin
               a_in = 28'(v_x_ff[2]) - 28'(v_x_ff[1]);
               b_in = 28'(v_y_ff[2]) - 28'(v_y_ff[1]);
            end
            ph_in = PhNrm;
         end
         PhNrm: begin
            // one doubling a cycle until the larger magnitude reaches 2^23
            if (a_ff == '0 && b_ff == '0) begin
               if (stage_ff == 2'd0) begin
                  pnx_in = '0; pny_in = '0; stage_in = 2'd1; ph_in = PhEdge;
               end else if (stage_ff == 2'd1) begin
                  qnx_in = '0; qny_in = '0; ph_in = PhBis;
               end else begin
                  offx_in = '0; offy_in = '0; ph_in = PhOut;
               end
            end else if (ma < 28'h800000 && mb < 28'h800000) begin
               a_in = a_ff <<< 1; b_in = b_ff <<< 1;
            end else begin
               mcalc_in = 1'b0; ph_in = PhMul;
            end
         end
         PhMul: begin
            // two squares on the shared multiplier, one per cycle
            if (!mcalc_ff) begin
               mul_in = 48'(ma[24:0]) * 48'(ma[24:0]);
               mcalc_in = 1'b1;
            end else begin
               s_in = 50'(mul_ff) + 50'(mb[24:0]) * 50'(mb[24:0]);
               rem_in = '0; root_in = '0; it_in = 6'd25; ph_in = PhSqrt;
            end
         end
         PhSqrt: begin
            // restoring square root, one result bit per cycle
            if (it_ff == '0) begin
               dsel_in = 2'd0; ph_in = PhDiv; it_in = 6'd0;
            end else begin
               logic [49:0] trial;
               logic [49:0] r2;
               r2 = {rem_ff, s_ff[49:48]};
               trial = 50'({root_ff, 2'b01});
               if (r2 >= trial) begin
                  rem_in = 48'(r2 - trial);
                  root_in = {root_ff[23:0], 1'b1};
               end else begin
                  rem_in = r2[47:0];
                  root_in = {root_ff[23:0], 1'b0};
               end
               s_in = s_ff << 2;
               it_in = it_ff - 6'd1;
            end
         end
         PhDiv: begin
            // two divides per stage, restoring, one bit per cycle over 48 bits
            if (it_ff == '0) begin
               logic signed [63:0] num;
               logic [63:0] m;
               logic signed [27:0] src;
               if (stage_ff == 2'd2) begin
                  src = (dsel_ff == 2'd0) ? a_ff : b_ff;
                  num = 64'(src) * 64'(distance);
               end else begin
                  src = (dsel_ff == 2'd0) ? -b_ff : a_ff;
                  if (inward_neg_ff) src = -src;
                  num = 64'(src) <<< 14;
               end
               m = num[63] ? 64'(-num) : 64'(num);
               dneg_in = num[63];
               dnum_in = 48'(m + 64'(root_ff >> 1));
               drem_in = '0; dq_in = '0; it_in = 6'd1;
            end else if (it_ff <= 6'd48) begin
               logic [26:0] r;
               r = {drem_ff, dnum_ff[47]};
               if (r >= 27'(root_ff)) begin
                  drem_in = 26'(r - 27'(root_ff)); dq_in = {dq_ff[30:0], 1'b1};
               end else begin
                  drem_in = r[25:0]; dq_in = {dq_ff[30:0], 1'b0};
               end
               dnum_in = dnum_ff << 1;
               it_in = it_ff + 6'd1;
            end else begin
               logic signed [31:0] q;
               q = dneg_ff ? -32'(dq_ff) : 32'(dq_ff);
               unique case (stage_ff)
                  2'd0: if (dsel_ff == 2'd0) pnx_in = 18'(q); else pny_in = 18'(q);
                  2'd1: if (dsel_ff == 2'd0) qnx_in = 18'(q); else qny_in = 18'(q);
                  default: if (dsel_ff == 2'd0) offx_in = q; else offy_in = q;
               endcase
               it_in = '0;
               if (dsel_ff == 2'd0) begin
                  dsel_in = 2'd1;
               end else if (stage_ff == 2'd0) begin
                  stage_in = 2'd1; ph_in = PhEdge;
               end else if (stage_ff == 2'd1) begin
                  ph_in = PhBis;
               end else begin
                  ph_in = PhOut;
               end
            end
         end
         PhBis: begin
            bx_s = pnx_ff + qnx_ff; by_s = pny_ff + qny_ff;
            if ((36'(bx_s) * 36'(bx_s) + 36'(by_s) * 36'(by_s)) <= 36'd2) begin
               bx_s = qnx_ff; by_s = qny_ff;
            end
            a_in = 28'(bx_s); b_in = 28'(by_s); stage_in = 2'd2; ph_in = PhNrm;
         end
         PhOut: begin
            if (!out_valid_ff || emit_take) begin
               sumx = 25'(v_x_ff[1]) + 25'(offx_ff);
               sumy = 25'(v_y_ff[1]) + 25'(offy_ff);
               out_in.inset_x = (offx_ff > 32'sd16777215 || sumx > 25'sd8388607) ?
                                24'h7fffff : (sumx < -25'sd8388608 ? 24'h800000 : sumx[23:0]);
               out_in.inset_y = (sumy > 25'sd8388607) ? 24'h7fffff :
                                (sumy < -25'sd8388608 ? 24'h800000 : sumy[23:0]);
               out_in.overflow = povf_ff;
               out_in.last_result = (idx_ff + CountWidth'(1) == n_ff);
               out_valid_in = 1'b1;
               if (idx_ff + CountWidth'(1) == n_ff) begin
                  ph_in = PhIdle;
               end else begin
                  idx_in = idx_ff + CountWidth'(1); ph_in = PhRdA;
               end
            end
         end
         PhHold, PhAreaA, PhAreaB: ph_in = PhIdle;
         default: ph_in = PhIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0; area_ff <= '0; ovf_ff <= 1'b0; ph_ff <= PhIdle;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in; area_ff <= area_in; ovf_ff <= ovf_in; ph_ff <= ph_in;
         out_valid_ff <= out_valid_in;
      end
      n_ff <= n_in; povf_ff <= povf_in; prev_x_ff <= prev_x_in; prev_y_ff <= prev_y_in;
      first_x_ff <= first_x_in; first_y_ff <= first_y_in; inward_neg_ff <= inward_neg_in;
      idx_ff <= idx_in; rcnt_ff <= rcnt_in; v_x_ff <= v_x_in; v_y_ff <= v_y_in;
      stage_ff <= stage_in; a_ff <= a_in; b_ff <= b_in; it_ff <= it_in;
      rem_ff <= rem_in; root_ff <= root_in; s_ff <= s_in; dsel_ff <= dsel_in;
      dnum_ff <= dnum_in; dq_ff <= dq_in; drem_ff <= drem_in; dneg_ff <= dneg_in;
      pnx_ff <= pnx_in; pny_ff <= pny_in; qnx_ff <= qnx_in; qny_ff <= qny_in;
      offx_ff <= offx_in; offy_ff <= offy_in;
      mcalc_ff <= mcalc_in; mul_ff <= mul_in; out_ff <= out_in;
   end

   assign emit_busy = (ph_ff != PhIdle);
   assign emit_valid = out_valid_ff;
   assign emit_data = out_ff;

   assert property (@(posedge clock) disable iff (reset)
      emit_valid && !emit_take |=> emit_valid && $stable(emit_data))
      else $error("pending result changed");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(MaxVertices))
      else $error("vertex count beyond store depth");
   assert property (@(posedge clock) disable iff (reset)
      close_en |=> count_ff == '0 && !ovf_ff)
      else $error("polygon state not cleared on close");
endmodule

// ===== rtl/core/poi_ctrl.sv =====
// controller: accepts requests, closes the polygon and launches the inset pass
module poi_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_last,
   input  logic             emit_busy,
   output logic             load_en,
   output logic             close_en,
   output logic             emit_start
);
   localparam logic [1:0] StLoad  = 2'd0;
   localparam logic [1:0] StClose = 2'd1;
   localparam logic [1:0] StStart = 2'd2;
   localparam logic [1:0] StRun   = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_ready = (state_ff == StLoad);
   assign load_en = req_valid && req_ready;
   assign close_en = (state_ff == StClose);
   assign emit_start = (state_ff == StStart);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StLoad:  if (load_en && req_last) state_in = StClose;
         StClose: state_in = StStart;
         StStart: state_in = StRun;
         StRun:   if (!emit_busy) state_in = StLoad;
         default: state_in = StLoad;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StLoad;
      end else begin
         state_ff <= state_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      load_en && req_last |=> close_en)
      else $error("closing request did not close polygon");
   assert property (@(posedge clock) disable iff (reset)
      close_en |=> emit_start)
      else $error("inset pass not launched");
   assert property (@(posedge clock) disable iff (reset)
      emit_start |-> !req_ready)
      else $error("request taken during inset pass");
endmodule

// ===== rtl/core/polygon_outline_inset.sv =====
// top level of the polygon outline inset block
// Loads a closed polygon one request per cycle (up to MaxVertices vertices, extra ones are
// dropped and flagged), then after the closing request emits one inset vertex per stored
// vertex in load order. The closing request is followed by a close state, which closes the
// area sum, and a start state, which launches the pass. For a polygon of three or more
// vertices each emitted vertex first reads three vertices, then for each edge normal and for
// the bisector doubles the vector until its larger component reaches 2^23, forms a square
// pair, takes a restoring square root and does two restoring divides, one quotient bit per
// cycle. A polygon of one or two vertices takes no offset and emits its vertices unchanged.
// A result waits in the output register until taken, which holds the next vertex back.
// No request is taken from the closing request until the last result has left the
// output register. The vertex store is a ram and needs no clearing after reset.
module polygon_outline_inset #(
   parameter int MaxVertices = poi_pkg::MaxVerticesDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  poi_pkg::req_type        req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output poi_pkg::rsp_type        rsp_data,
   input  logic                    csr_write,
   input  logic signed [15:0]      csr_wdata
);
   // configured inset distance, signed integer in vertex coordinate units
   logic signed [15:0] dist_ff;
   logic load_en, close_en, emit_start, emit_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= '0;
      end else if (csr_write) begin
         dist_ff <= csr_wdata;
      end
   end

   poi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_last   (req_data.last_vertex),
      .emit_busy  (emit_busy || rsp_valid),
      .load_en    (load_en),
      .close_en   (close_en),
      .emit_start (emit_start)
   );

   poi_datapath #(.MaxVertices(MaxVertices)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .load_en    (load_en),
      .req_data   (req_data),
      .close_en   (close_en),
      .emit_start (emit_start),
      .emit_take  (rsp_valid && rsp_ready),
      .distance   (dist_ff),
      .emit_busy  (emit_busy),
      .emit_valid (rsp_valid),
      .emit_data  (rsp_data)
   );
endmodule
